// File: sv/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("check failed");
`define CHK_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("check failed");
`endif

// File: sv/mom_pkg.sv
package mom_pkg;
   localparam int CalSamples = 10;
   localparam int CntW = 5;
   localparam logic [CntW-1:0] CalLast = CntW'(CalSamples - 1);
   // trimmed mean divisor as a reciprocal, exact for magnitudes below 2**21
   localparam int TrimDivisor = CalSamples - 2;
   localparam int TrimShift = 21 + $clog2(TrimDivisor);
   localparam longint unsigned TrimRecip =
      ((64'd1 << TrimShift) + longint'(TrimDivisor) - 64'd1) / longint'(TrimDivisor);
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_WEAK = 2'd1;
   localparam logic [1:0] ST_CAL = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;
   localparam logic [0:0] REG_DIV = 1'b0;
   localparam logic [0:0] REG_LIM = 1'b1;
   typedef enum logic [2:0] {S_IDLE, S_DIV, S_ACC, S_TRIM, S_SQ, S_SQRT, S_OUT} state_type;
   typedef struct packed {
      logic start;
      logic [15:0] divisor;
   } lane_ctl_type;
endpackage

// File: sv/mom_if.sv
interface mom_req_if;
   logic valid;
   logic ready;
   logic kind;
   logic signed [15:0] raw_x;
   logic signed [15:0] raw_y;
   logic signed [15:0] raw_z;
   modport source (output valid, kind, raw_x, raw_y, raw_z, input ready);
   modport sink (input valid, kind, raw_x, raw_y, raw_z, output ready);
endinterface

interface mom_rsp_if;
   logic valid;
   logic ready;
   logic signed [15:0] field_x;
   logic signed [15:0] field_y;
   logic signed [15:0] field_z;
   logic [15:0] magnitude;
   logic [1:0] status;
   modport source (output valid, field_x, field_y, field_z, magnitude, status, input ready);
   modport sink (input valid, field_x, field_y, field_z, magnitude, status, output ready);
endinterface

// File: sv/mom_div_lane.sv
// signed 22-bit dividend by unsigned 16-bit divisor, truncating, one bit a cycle
module mom_div_lane (
   input  logic clock,
   input  logic reset,
   input  mom_pkg::lane_ctl_type ctl,
   input  logic signed [21:0] dividend,
   output logic signed [21:0] quotient,
   output logic busy
);
   import mom_pkg::*;
   logic [21:0] q_ff, q_in;
   logic [16:0] r_ff, r_in;
   logic [15:0] d_ff, d_in;
   logic neg_ff, neg_in;
   logic [4:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [16:0] trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; busy_in = busy_ff;
      trial = {r_ff[15:0], q_ff[21]} - {1'b0, d_ff};
      if (ctl.start) begin
         neg_in = dividend[21];
         q_in = dividend[21] ? 22'(-dividend) : dividend;
         r_in = '0;
         d_in = ctl.divisor;
         cnt_in = 5'd21;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[16]) begin
            r_in = trial;
            q_in = {q_ff[20:0], 1'b1};
         end else begin
            r_in = {r_ff[15:0], q_ff[21]};
            q_in = {q_ff[20:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; neg_ff <= neg_in; cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   assign busy = busy_ff;
   assign quotient = neg_ff ? -$signed(q_ff) : $signed(q_ff);
endmodule

// File: sv/mom_sqrt.sv
// bit-serial floor square root of a 35-bit value, saturating at 16 bits, one result bit a cycle
module mom_sqrt (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [34:0] radicand,
   output logic [15:0] root,
   output logic busy
);
   import mom_pkg::*;
   logic [15:0] r_ff, r_in;
   logic [34:0] v_ff, v_in;
   logic [3:0] b_ff, b_in;
   logic busy_ff, busy_in;
   logic [15:0] t;
   logic [31:0] tsq;

   always_comb begin
      r_in = r_ff; v_in = v_ff; b_in = b_ff; busy_in = busy_ff;
      t = r_ff | (16'd1 << b_ff);
      tsq = t * t;
      if (start) begin
         r_in = '0; v_in = radicand; b_in = 4'd15; busy_in = 1'b1;
      end else if (busy_ff) begin
         if ({3'b0, tsq} <= v_ff) r_in = t;
         b_in = b_ff - 4'd1;
         if (b_ff == 4'd0) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in; v_ff <= v_in; b_ff <= b_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   assign root = r_ff;
   assign busy = busy_ff;
endmodule

// File: sv/magnetometer_offset_and_magnitude.sv
// a calibration sample passes S_DIV, S_ACC and S_OUT; the one that closes the round
//    stays in S_ACC to latch the trimmed sums, then passes S_TRIM; a measure sample
//    passes S_DIV, S_SQ, S_SQRT and S_OUT (22 divider steps, 16 root steps)
// one sample in flight; a waiting result stalls S_OUT and so holds off the next beat
// reset (synchronous, active high): offsets, round count and sums cleared,
//    divisor 3000, near-zero limit 3
module magnetometer_offset_and_magnitude (
   input  logic clock,
   input  logic reset,
   mom_req_if.sink req,
   mom_rsp_if.source rsp,
   input  logic csr_we,
   input  logic [0:0] csr_index,
   input  logic [14:0] csr_wdata
);
   import mom_pkg::*;

   // configuration registers
   logic [14:0] div_ff, lim_ff;
   // calibration state
   logic signed [15:0] off_ff [3];
   logic signed [20:0] sum_ff [3];
   logic signed [15:0] mn_ff [3], mx_ff [3];
   logic [CntW-1:0] cnt_ff;
   // working registers
   state_type state_ff, state_in;
   logic kind_ff;
   logic signed [15:0] s_ff [3];
   logic signed [15:0] f_ff [3];
   logic [31:0] sq_ff [3];
   logic [1:0] sqi_ff;
   logic [34:0] acc_ff;
   logic done_ff;
   logic signed [20:0] trim_ff [3];
   // result register
   logic rv_ff;
   logic signed [15:0] ox_ff, oy_ff, oz_ff;
   logic [15:0] om_ff;
   logic [1:0] os_ff;

   lane_ctl_type ctl;
   logic signed [21:0] dvd [3];
   logic signed [21:0] quo [3];
   logic [2:0] lbusy;
   logic sq_start, sq_busy;
   logic [34:0] radicand;
   logic [15:0] root;
   logic signed [20:0] trim [3];
   logic [20:0] tmag [3];
   logic [43:0] tprod [3];
   logic [15:0] tq [3];
   logic out_load;

   // lanes run the scaling division of each axis
   assign ctl.divisor = (div_ff == 15'd0) ? 16'd1 : {1'b0, div_ff};
   assign ctl.start = (state_ff == S_IDLE) && req.valid && req.ready;

   for (genvar i = 0; i < 3; i++) begin : g_lane
      logic signed [15:0] rin;
      assign rin = (i == 0) ? req.raw_x : (i == 1) ? req.raw_y : req.raw_z;
      assign dvd[i] = 22'(rin);
      mom_div_lane u_lane (.clock, .reset, .ctl, .dividend(dvd[i]),
                           .quotient(quo[i]), .busy(lbusy[i]));
      // trimmed mean: magnitude times a fixed reciprocal, sign put back after
      assign trim[i] = sum_ff[i] - 21'(mn_ff[i]) - 21'(mx_ff[i]);
      assign tmag[i] = trim_ff[i][20] ? 21'(-trim_ff[i]) : 21'(trim_ff[i]);
      assign tprod[i] = 44'(tmag[i]) * 44'(TrimRecip);
      assign tq[i] = 16'(tprod[i] >> TrimShift);
   end

   // input is free whenever the core is idle, a waiting result only stalls S_OUT
   assign req.ready = (state_ff == S_IDLE);
   assign out_load = (state_ff == S_OUT) && (!rv_ff || rsp.ready);
   assign sq_start = (state_ff == S_SQ) && (sqi_ff == 2'd3);
   // last lane product joins the sum as the root starts
   assign radicand = acc_ff + 35'(sq_ff[2]);

   mom_sqrt u_sqrt (.clock, .reset, .start(sq_start), .radicand,
                    .root, .busy(sq_busy));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req.valid && req.ready) state_in = S_DIV;
         S_DIV: if (!lbusy[0] && !ctl.start) state_in = kind_ff ? S_ACC : S_SQ;
         // closing sample stays in S_ACC after its merge to latch the trimmed sums
         S_ACC: begin
            if (done_ff) state_in = S_TRIM;
            else if (cnt_ff != CalLast) state_in = S_OUT;
         end
         S_TRIM: state_in = S_OUT;
         S_SQ: if (sqi_ff == 2'd3) state_in = S_SQRT;
         S_SQRT: if (!sq_busy && !sq_start) state_in = S_OUT;
         S_OUT: if (out_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   logic is_weak;
   always_comb begin
      is_weak = lim_ff != 15'd0;
      for (int i = 0; i < 3; i++)
         if (!(s_ff[i] < $signed({1'b0, lim_ff}) && s_ff[i] > -$signed({1'b0, lim_ff})))
            is_weak = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         div_ff <= 15'd3000;
         lim_ff <= 15'd3;
         cnt_ff <= '0;
         rv_ff <= 1'b0;
         done_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            off_ff[i] <= '0;
            sum_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_DIV: div_ff <= csr_wdata;
               REG_LIM: lim_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (out_load) rv_ff <= 1'b1;
         else if (rsp.valid && rsp.ready) rv_ff <= 1'b0;
         if (state_ff == S_IDLE && req.valid && req.ready) begin
            kind_ff <= req.kind;
            sqi_ff <= '0;
            acc_ff <= '0;
         end
         if (state_ff == S_DIV && state_in != S_DIV) begin
            for (int i = 0; i < 3; i++) begin
               s_ff[i] <= quo[i][15:0];
               f_ff[i] <= quo[i][15:0] - off_ff[i];
            end
         end
         // merge: accumulate the round, track extremes; once the round is done, latch the trimmed sums
         if (state_ff == S_ACC) begin
            if (!done_ff) begin
               for (int i = 0; i < 3; i++) begin
                  if (cnt_ff == '0) begin
                     sum_ff[i] <= 21'(s_ff[i]);
                     mn_ff[i] <= s_ff[i];
                     mx_ff[i] <= s_ff[i];
                  end else begin
                     sum_ff[i] <= sum_ff[i] + 21'(s_ff[i]);
                     if (s_ff[i] < mn_ff[i]) mn_ff[i] <= s_ff[i];
                     if (s_ff[i] > mx_ff[i]) mx_ff[i] <= s_ff[i];
                  end
               end
               if (cnt_ff == CalLast) begin
                  done_ff <= 1'b1;
                  cnt_ff <= '0;
               end else cnt_ff <= cnt_ff + 1'b1;
            end else begin
               for (int i = 0; i < 3; i++) trim_ff[i] <= trim[i];
            end
         end
         if (state_ff == S_DIV && state_in == S_ACC) done_ff <= 1'b0;
         // merge: sum of squares, one lane product a cycle
         if (state_ff == S_SQ) begin
            if (sqi_ff != 2'd3) begin
               sq_ff[sqi_ff] <= 32'(32'(f_ff[sqi_ff]) * 32'(f_ff[sqi_ff]));
               if (sqi_ff != 2'd0) acc_ff <= acc_ff + 35'(sq_ff[sqi_ff - 2'd1]);
               sqi_ff <= sqi_ff + 2'd1;
            end
         end
         if (out_load) begin
            if (kind_ff) begin
               if (done_ff) begin
                  ox_ff <= off_ff[0]; oy_ff <= off_ff[1]; oz_ff <= off_ff[2];
                  os_ff <= ST_DONE;
               end else begin
                  ox_ff <= '0; oy_ff <= '0; oz_ff <= '0;
                  os_ff <= ST_CAL;
               end
               om_ff <= '0;
            end else begin
               ox_ff <= f_ff[0]; oy_ff <= f_ff[1]; oz_ff <= f_ff[2];
               om_ff <= root;
               os_ff <= is_weak ? ST_WEAK : ST_OK;
            end
         end
         if (state_ff == S_TRIM) begin
            for (int i = 0; i < 3; i++) begin
               off_ff[i] <= trim_ff[i][20] ? -tq[i] : tq[i];
               sum_ff[i] <= '0;
            end
         end
      end
   end

   assign rsp.valid = rv_ff;
   assign rsp.field_x = ox_ff;
   assign rsp.field_y = oy_ff;
   assign rsp.field_z = oz_ff;
   assign rsp.magnitude = om_ff;
   assign rsp.status = os_ff;
endmodule

// File: sv/mom_checker.sv
`include "assert_macros.svh"
module mom_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [1:0] rsp_status,
   input logic [15:0] rsp_magnitude
);
   `CHK_IMPL(a_cal_mag, clock, reset, rsp_valid && rsp_status[1], rsp_magnitude == 16'd0)
   `CHK_NEXT(a_hold_data, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_status) && $stable(rsp_magnitude))
   `CHK_NEXT(a_one_at_time, clock, reset, req_valid && req_ready, !req_ready)
   `CHK_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
endmodule

bind magnetometer_offset_and_magnitude mom_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.status),
   .rsp_magnitude(rsp.magnitude));
